### hw/rtl/mskf_pkg.sv
// mskf_pkg: shared types and constants for the multichannel scalar kalman filter
// state and operation encodings, register indexes and reset values
// no dependencies
package mskf_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_POST,
		ST_DIVINIT,
		ST_DIV,
		ST_KSET,
		ST_WB
	} mskf_state_t;

	typedef enum logic [2:0] {
		OP_PH,
		OP_NH,
		OP_HX,
		OP_KE,
		OP_KH,
		OP_GP
	} mskf_op_t;

	localparam logic [1:0] REG_R_IDX = 2'd0;
	localparam logic [1:0] REG_Q_IDX = 2'd1;
	localparam logic [1:0] REG_H_IDX = 2'd2;

	localparam logic [31:0] R_RESET = 32'd2621440;
	localparam logic [31:0] Q_RESET = 32'd655360;
	localparam logic [31:0] H_RESET = 32'd65536;

	localparam logic [3:0] MUL_LAST = 4'd8;
	localparam logic [4:0] DIV_LAST = 5'd31;

endpackage

### hw/rtl/multichannel_scalar_kalman_filter_top.sv
// multichannel scalar kalman filter, one channel update per input transfer
// radix-16 shift-add multiplier shared by all six multiplies, radix-2 divider for the gain
// depends on mskf_pkg
//
// steps: load, multiplies PH, NH and HX, the 32-step quotient loop, then multiplies
// KE, KH and GP; the loop is skipped if the denominator is zero or the quotient
// saturates; new inputs stall until writeback, out-of-range channels skip to it
// reset: config registers load R=40, Q=10, H=1.0, every channel reads as zero
module multichannel_scalar_kalman_filter_top
	import mskf_pkg::*;
#(
	parameter int CHANNELS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         channel,
	input  logic signed [31:0] measurement,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         channel_out,
	output logic signed [31:0] estimate
);

	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_EXT_W = (IDX_W > 4) ? IDX_W : 4;

	function automatic logic [31:0] sat_s32(input logic [59:0] v);
		logic [31:0] r;
		if ((v[59:31] == '0) || (v[59:31] == '1)) begin
			r = v[31:0];
		end else begin
			r = v[59] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return r;
	endfunction

	mskf_state_t state_q, state_d;
	mskf_op_t    op_q;
	logic [3:0]  mcnt_q;
	logic [4:0]  dcnt_q;

	logic [31:0] measurement_noise_q;
	logic [31:0] process_noise_q;
	logic [31:0] measurement_gain_q;

	logic [63:0] mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	logic [63:0] rd_q;
	logic        rd_vld_q;

	logic [3:0]  channel_q;
	logic [31:0] z_q;
	logic        ch_ok_q;
	logic [31:0] x_q;
	logic [31:0] p_q;
	logic [31:0] num_q;
	logic [48:0] den_q;
	logic [31:0] hx_q;
	logic [31:0] e_q;
	logic [31:0] k_q;
	logic [31:0] xn_q;
	logic [31:0] pn_q;
	logic [48:0] rem_q;
	logic [31:0] quo_q;

	logic [31:0]        ma_q;
	logic [35:0]        mb_q;
	logic signed [37:0] mhi_q;
	logic [35:0]        mlo_q;

	logic               out_valid_q;
	logic [3:0]         chan_out_q;
	logic [31:0]        est_out_q;

	logic [CH_EXT_W-1:0] ch_in_ext, ch_q_ext;
	logic [IDX_W-1:0]    rd_idx, wr_idx;
	logic                ch_in_ok;
	logic                in_xfer;
	logic                out_free;
	logic                wb_fire;
	logic                mem_we;
	logic                cfg_we;

	logic               mlast;
	logic [3:0]         mdig;
	logic signed [37:0] pp;
	logic signed [37:0] msum;
	logic [57:0]        prodsh;

	logic [31:0] x_ld, p_ld;
	logic [31:0] num_w;
	logic [48:0] den_w;
	logic [47:0] kh_w;
	logic [16:0] g_w;
	logic [33:0] pn_sum;
	logic [31:0] pn_w;
	logic [32:0] ediff;
	logic [58:0] xsum;
	logic        div_zero, div_sat;
	logic [50:0] trial;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measurement_noise_q <= R_RESET;
			process_noise_q     <= Q_RESET;
			measurement_gain_q  <= H_RESET;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_R_IDX: measurement_noise_q <= pwdata;
				REG_Q_IDX: process_noise_q     <= pwdata;
				REG_H_IDX: measurement_gain_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_R_IDX: prdata = measurement_noise_q;
			REG_Q_IDX: prdata = process_noise_q;
			REG_H_IDX: prdata = measurement_gain_q;
			default:   prdata = '0;
		endcase
	end

	// channel decode
	assign ch_in_ext = CH_EXT_W'(channel);
	assign ch_q_ext  = CH_EXT_W'(channel_q);
	assign rd_idx    = ch_in_ext[IDX_W-1:0];
	assign wr_idx    = ch_q_ext[IDX_W-1:0];
	assign ch_in_ok  = ({28'b0, channel} < 32'(CHANNELS));

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign wb_fire  = (state_q == ST_WB) && out_free;
	assign mem_we   = wb_fire && ch_ok_q;

	// multiplier digit step
	assign mdig   = mb_q[3:0];
	assign mlast  = (mcnt_q == MUL_LAST);
	assign pp     = $signed({6'b0, ma_q}) * $signed({{34{mlast & mdig[3]}}, mdig});
	assign msum   = mhi_q + pp;
	assign prodsh = {mhi_q, mlo_q[35:16]};

	// result shaping
	assign x_ld   = rd_vld_q ? rd_q[63:32] : '0;
	assign p_ld   = rd_vld_q ? rd_q[31:0] : '0;
	assign num_w  = (prodsh[57:32] != '0) ? 32'hffff_ffff : prodsh[31:0];
	assign den_w  = {1'b0, prodsh[47:0]} + {17'b0, measurement_noise_q};
	assign kh_w   = prodsh[47:0];
	assign g_w    = (kh_w > 48'd65536) ? 17'd0 : 17'(48'd65536 - kh_w);
	assign pn_sum = {1'b0, prodsh[32:0]} + {2'b0, process_noise_q};
	assign pn_w   = (pn_sum[33:32] != 2'b00) ? 32'hffff_ffff : pn_sum[31:0];
	assign ediff  = {z_q[31], z_q} - {hx_q[31], hx_q};
	assign xsum   = {{27{x_q[31]}}, x_q} + {prodsh[57], prodsh};

	// divider
	assign div_zero = (den_q == '0);
	assign div_sat  = ({33'b0, num_q[31:16]} >= den_q);
	assign trial    = {1'b0, rem_q, quo_q[31]} - {2'b0, den_q};

	// state register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ch_in_ok ? ST_LOAD : ST_WB;
				end
			end
			ST_LOAD:    state_d = ST_MUL;
			ST_MUL: begin
				if (mlast) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				case (op_q)
					OP_HX:   state_d = ST_DIVINIT;
					OP_GP:   state_d = ST_WB;
					default: state_d = ST_MUL;
				endcase
			end
			ST_DIVINIT: state_d = (div_zero || div_sat) ? ST_KSET : ST_DIV;
			ST_DIV: begin
				if (dcnt_q == DIV_LAST) begin
					state_d = ST_KSET;
				end
			end
			ST_KSET:    state_d = ST_MUL;
			ST_WB: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_PH;
			mcnt_q      <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			mcnt_q <= (state_q == ST_MUL) ? mcnt_q + 4'd1 : 4'd0;
			dcnt_q <= (state_q == ST_DIV) ? dcnt_q + 5'd1 : 5'd0;
			if (state_q == ST_LOAD) begin
				op_q <= OP_PH;
			end else if (state_q == ST_KSET) begin
				op_q <= OP_KE;
			end else if (state_q == ST_POST) begin
				case (op_q)
					OP_PH:   op_q <= OP_NH;
					OP_NH:   op_q <= OP_HX;
					OP_KE:   op_q <= OP_KH;
					OP_KH:   op_q <= OP_GP;
					default: op_q <= op_q;
				endcase
			end
			if (wb_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[wr_idx] <= 1'b1;
			end
		end
	end

	// channel state memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= {xn_q, pn_q};
		end
		if (in_xfer && ch_in_ok) begin
			rd_q     <= mem[rd_idx];
			rd_vld_q <= vld_q[rd_idx];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					channel_q <= channel;
					z_q       <= measurement;
					ch_ok_q   <= ch_in_ok;
				end
			end
			ST_LOAD: begin
				x_q   <= x_ld;
				p_q   <= p_ld;
				ma_q  <= measurement_gain_q;
				mb_q  <= {4'b0, p_ld};
				mhi_q <= '0;
			end
			ST_MUL: begin
				mhi_q <= msum >>> 4;
				mlo_q <= {msum[3:0], mlo_q[35:4]};
				mb_q  <= {{4{mb_q[35]}}, mb_q[35:4]};
			end
			ST_POST: begin
				case (op_q)
					OP_PH: begin
						num_q <= num_w;
						ma_q  <= measurement_gain_q;
						mb_q  <= {4'b0, num_w};
						mhi_q <= '0;
					end
					OP_NH: begin
						den_q <= den_w;
						ma_q  <= measurement_gain_q;
						mb_q  <= {{4{x_q[31]}}, x_q};
						mhi_q <= '0;
					end
					OP_HX: begin
						hx_q <= sat_s32({{2{prodsh[57]}}, prodsh});
					end
					OP_KE: begin
						xn_q  <= sat_s32({xsum[58], xsum});
						ma_q  <= k_q;
						mb_q  <= {4'b0, measurement_gain_q};
						mhi_q <= '0;
					end
					OP_KH: begin
						ma_q  <= p_q;
						mb_q  <= {19'b0, g_w};
						mhi_q <= '0;
					end
					OP_GP: begin
						pn_q <= pn_w;
					end
					default: ;
				endcase
			end
			ST_DIVINIT: begin
				e_q   <= sat_s32({{27{ediff[32]}}, ediff});
				rem_q <= {33'b0, num_q[31:16]};
				if (div_zero) begin
					quo_q <= '0;
				end else if (div_sat) begin
					quo_q <= '1;
				end else begin
					quo_q <= {num_q[15:0], 16'b0};
				end
			end
			ST_DIV: begin
				if (!trial[50]) begin
					rem_q <= trial[48:0];
				end else begin
					rem_q <= {rem_q[47:0], quo_q[31]};
				end
				quo_q <= {quo_q[30:0], !trial[50]};
			end
			ST_KSET: begin
				k_q   <= quo_q;
				ma_q  <= quo_q;
				mb_q  <= {{4{e_q[31]}}, e_q};
				mhi_q <= '0;
			end
			ST_WB: begin
				if (out_free) begin
					chan_out_q <= channel_q;
					est_out_q  <= ch_ok_q ? xn_q : 32'd0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign channel_out = chan_out_q;
	assign estimate    = est_out_q;

	// checks
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input transfer not followed by stall");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below denominator");

	a_cov_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_fire && ch_ok_q) |-> (pn_q >= process_noise_q))
		else $error("covariance below process noise at writeback");

	a_post_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POST) |-> ($past(state_q) == ST_MUL && $past(mcnt_q) == MUL_LAST))
		else $error("product used before all digits done");

endmodule
